>>> design/tensor_grid_point_locator_assert.svh
// Assertion macros used by the checker file of the point locator.
`ifndef TENSOR_GRID_POINT_LOCATOR_ASSERT_SVH
`define TENSOR_GRID_POINT_LOCATOR_ASSERT_SVH

// same-cycle implication
`define TGPL_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tgpl assertion failed");

// next-cycle implication
`define TGPL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tgpl assertion failed");

`endif

>>> design/tgpl_pkg.sv
// Shared types, codes and helpers of the tensor grid point locator.
package tgpl_pkg;

   localparam int CFG_W = 9;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_KNOTS_X = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KNOTS_Y = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KNOTS_Z = 2'd2;

   localparam logic [CFG_W-1:0] KNOTS_RESET = 9'd2;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_LOCATE = 1'b1;

   localparam int FLAT_W = 24;

   typedef struct packed {
      logic               op;
      logic [1:0]         direction;
      logic [7:0]         knot_slot;
      logic signed [31:0] knot_value;
      logic signed [31:0] coord_x;
      logic signed [31:0] coord_y;
      logic signed [31:0] coord_z;
      logic [15:0]        point_tag;
   } req_type;

   typedef struct packed {
      logic [15:0]       tag_out;
      logic [7:0]        elem_x;
      logic [7:0]        elem_y;
      logic [7:0]        elem_z;
      logic [FLAT_W-1:0] elem_flat;
      logic              outside_range;
      logic              on_internal_line;
   } rsp_type;

   // signed order of two Q16.16 words
   function automatic logic lt_s32(input logic signed [31:0] a, input logic signed [31:0] b);
      return a < b;
   endfunction

endpackage

>>> design/tgpl_ram.sv
// Generic RAM: one write port, two registered read ports.
module tgpl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
   input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
   output logic [WIDTH-1:0]         rd_a_data,
   output logic [WIDTH-1:0]         rd_b_data
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_a_addr];
         rd_b_ff <= mem_ff[rd_b_addr];
      end
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

>>> design/tgpl_lane.sv
// One direction: pipelined lower-bound searches over replicated knot tables.
module tgpl_lane #(
   parameter int MAX_KNOTS  = 256,
   parameter int LANE_INDEX = 0
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  logic                             accept,
   input  tgpl_pkg::req_type                req,
   input  logic [$clog2(MAX_KNOTS+1)-1:0]   n_in,
   output logic [$clog2(MAX_KNOTS+1)-1:0]   elem,
   output logic [$clog2(MAX_KNOTS+1)-1:0]   span,
   output logic                             outside,
   output logic                             online
);

   localparam int AW    = $clog2(MAX_KNOTS);
   localparam int CW    = $clog2(MAX_KNOTS+1);
   localparam int STEPS = CW;
   localparam int LAST  = STEPS + 1;

   logic              wr_ff    [0:STEPS];
   logic [AW-1:0]     slot_ff  [0:STEPS];
   logic [31:0]       value_ff [0:STEPS];
   logic signed [31:0] c_ff    [0:LAST];
   logic [CW-1:0]     n_ff     [0:LAST];
   logic [CW-1:0]     a_lo_ff  [0:LAST];
   logic [CW-1:0]     b_lo_ff  [0:LAST];
   logic [CW-1:0]     a_len_ff [0:STEPS];
   logic [CW-1:0]     b_len_ff [0:STEPS];
   logic [31:0]       ep0_ff   [2:LAST];
   logic [31:0]       epn_ff   [2:LAST];

   logic [CW-1:0]     na_lo  [0:STEPS];
   logic [CW-1:0]     na_len [0:STEPS];
   logic [CW-1:0]     nb_lo  [0:STEPS];
   logic [CW-1:0]     nb_len [0:STEPS];
   logic [31:0]       rd_a   [0:LAST];
   logic [31:0]       rd_b   [0:LAST];

   logic signed [31:0] coord_sel;
   logic               wr_in;

   function automatic logic [2*CW-1:0] probe(input logic [CW-1:0] lo, input logic [CW-1:0] len,
                                             input logic [31:0] knot,
                                             input logic signed [31:0] c);
      logic [CW-1:0] half;
      logic [CW-1:0] p;
      half = len >> 1;
      p = lo + half;
      if (len == '0) begin
         return {lo, len};
      end
      if (tgpl_pkg::lt_s32(knot, c)) begin
         return {p + CW'(1), len - half - CW'(1)};
      end
      return {lo, half};
   endfunction

   always_comb begin
      unique case (LANE_INDEX)
         0:       coord_sel = req.coord_x;
         1:       coord_sel = req.coord_y;
         default: coord_sel = req.coord_z;
      endcase
   end

   assign wr_in = accept && (req.op == tgpl_pkg::OP_WRITE)
                  && (req.direction == 2'(LANE_INDEX))
                  && (int'(req.knot_slot) < MAX_KNOTS);

   // stage 0
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff[0] <= 1'b0;
      end else if (advance) begin
         wr_ff[0] <= wr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         slot_ff[0]  <= AW'(req.knot_slot);
         value_ff[0] <= req.knot_value;
         c_ff[0]     <= coord_sel;
         n_ff[0]     <= n_in;
         a_lo_ff[0]  <= '0;
         a_len_ff[0] <= n_in;
         b_lo_ff[0]  <= CW'(1);
         b_len_ff[0] <= n_in - CW'(2);
      end
   end

   // search state after each probe
   assign na_lo[0]  = a_lo_ff[0];
   assign na_len[0] = a_len_ff[0];
   assign nb_lo[0]  = b_lo_ff[0];
   assign nb_len[0] = b_len_ff[0];

   genvar k;
   generate
      for (k = 1; k <= STEPS; k++) begin : g_probe
         assign {na_lo[k], na_len[k]} = probe(a_lo_ff[k], a_len_ff[k], rd_a[k], c_ff[k]);
         assign {nb_lo[k], nb_len[k]} = probe(b_lo_ff[k], b_len_ff[k], rd_b[k], c_ff[k]);
      end

      for (k = 1; k <= LAST; k++) begin : g_stage
         always_ff @(posedge clock) begin
            if (advance) begin
               c_ff[k]    <= c_ff[k-1];
               n_ff[k]    <= n_ff[k-1];
               a_lo_ff[k] <= na_lo[k-1];
               b_lo_ff[k] <= nb_lo[k-1];
            end
         end
         if (k <= STEPS) begin : g_len
            always_ff @(posedge clock) begin
               if (reset) begin
                  wr_ff[k] <= 1'b0;
               end else if (advance) begin
                  wr_ff[k] <= wr_ff[k-1];
               end
            end
            always_ff @(posedge clock) begin
               if (advance) begin
                  slot_ff[k]  <= slot_ff[k-1];
                  value_ff[k] <= value_ff[k-1];
                  a_len_ff[k] <= na_len[k-1];
                  b_len_ff[k] <= nb_len[k-1];
               end
            end
         end
         if (k == 2) begin : g_ep_first
            always_ff @(posedge clock) begin
               if (advance) begin
                  ep0_ff[k] <= rd_a[0];
                  epn_ff[k] <= rd_b[0];
               end
            end
         end else if (k > 2) begin : g_ep_carry
            always_ff @(posedge clock) begin
               if (advance) begin
                  ep0_ff[k] <= ep0_ff[k-1];
                  epn_ff[k] <= epn_ff[k-1];
               end
            end
         end
      end

      // table copies; each is written as a write request enters its stage
      genvar r;
      for (r = 0; r <= LAST; r++) begin : g_ram
         localparam int WS = (r == 0) ? 0 : r - 1;
         logic [AW-1:0] addr_a;
         logic [AW-1:0] addr_b;
         logic [CW-1:0] pos_a;
         logic [CW-1:0] pos_b;

         if (r == 0) begin : g_ends
            assign pos_a = '0;
            assign pos_b = n_ff[0] - CW'(1);
         end else if (r <= STEPS) begin : g_mid
            assign pos_a = na_lo[r-1] + (na_len[r-1] >> 1);
            assign pos_b = nb_lo[r-1] + (nb_len[r-1] >> 1);
         end else begin : g_tail
            assign pos_a = nb_lo[STEPS];
            assign pos_b = '0;
         end
         assign addr_a = pos_a[AW-1:0];
         assign addr_b = pos_b[AW-1:0];

         tgpl_ram #(
            .WIDTH(32),
            .DEPTH(MAX_KNOTS)
         ) u_ram (
            .clock     (clock),
            .wr_en     (advance && wr_ff[WS]),
            .wr_addr   (slot_ff[WS]),
            .wr_data   (value_ff[WS]),
            .rd_en     (advance),
            .rd_a_addr (addr_a),
            .rd_b_addr (addr_b),
            .rd_a_data (rd_a[r]),
            .rd_b_data (rd_b[r])
         );
      end
   endgenerate

   // result of the last stage
   logic [CW-1:0] e_raw;
   logic [CW-1:0] n_m2;

   always_comb begin
      n_m2  = n_ff[LAST] - CW'(2);
      e_raw = (a_lo_ff[LAST] != '0) ? a_lo_ff[LAST] - CW'(1) : '0;
      elem  = (e_raw > n_m2) ? n_m2 : e_raw;
      span  = n_ff[LAST] - CW'(1);
      outside = tgpl_pkg::lt_s32(c_ff[LAST], ep0_ff[LAST])
                || tgpl_pkg::lt_s32(epn_ff[LAST], c_ff[LAST]);
      online  = (b_lo_ff[LAST] < span) && (rd_a[LAST] == c_ff[LAST]);
   end

endmodule

>>> design/tensor_grid_point_locator.sv
// Top level of the tensor grid point locator.
// Takes one request per clock while req_stall is low: a knot write or a point
// locate. Each direction runs its two lower-bound searches in a pipeline of
// clog2(MAX_KNOTS+1) probe stages, each stage reading its own copy of the knot
// table. Writes travel the same pipeline and update each table copy as they pass,
// so every locate sees exactly the writes taken before it. The pipeline halts
// only while a response waits and rsp_stall is high. The knot tables are not
// cleared; a locate must touch written entries.
module tensor_grid_point_locator #(
   parameter int DIRECTIONS = 3,
   parameter int MAX_KNOTS  = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  tgpl_pkg::req_type                    req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output tgpl_pkg::rsp_type                    rsp_payload,
   input  logic                                 csr_write_enable,
   input  logic [tgpl_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tgpl_pkg::CFG_W-1:0]           csr_write_data
);

   localparam int CW   = $clog2(MAX_KNOTS+1);
   localparam int LAST = CW + 1;
   localparam int FW   = tgpl_pkg::FLAT_W;

   logic [tgpl_pkg::CFG_W-1:0] cfg_ff [0:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff[0] <= tgpl_pkg::KNOTS_RESET;
         cfg_ff[1] <= tgpl_pkg::KNOTS_RESET;
         cfg_ff[2] <= tgpl_pkg::KNOTS_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            tgpl_pkg::CSR_KNOTS_X: cfg_ff[0] <= csr_write_data;
            tgpl_pkg::CSR_KNOTS_Y: cfg_ff[1] <= csr_write_data;
            tgpl_pkg::CSR_KNOTS_Z: cfg_ff[2] <= csr_write_data;
            default: ;
         endcase
      end
   end

   function automatic logic [CW-1:0] clamp_n(input logic [tgpl_pkg::CFG_W-1:0] v);
      if (int'(v) < 2) begin
         return CW'(2);
      end
      if (int'(v) > MAX_KNOTS) begin
         return CW'(MAX_KNOTS);
      end
      return CW'(v);
   endfunction

   logic rsp_valid_ff;
   logic advance;
   logic accept;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign advance   = !req_stall;
   assign accept    = req_valid && advance;

   // locate valid and tag travel beside the lanes
   logic        loc_ff [0:LAST];
   logic [15:0] tag_ff [0:LAST];

   always_ff @(posedge clock) begin
      if (reset) begin
         loc_ff[0] <= 1'b0;
      end else if (advance) begin
         loc_ff[0] <= accept && (req_payload.op == tgpl_pkg::OP_LOCATE);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tag_ff[0] <= req_payload.point_tag;
      end
   end

   genvar s;
   generate
      for (s = 1; s <= LAST; s++) begin : g_tag
         always_ff @(posedge clock) begin
            if (reset) begin
               loc_ff[s] <= 1'b0;
            end else if (advance) begin
               loc_ff[s] <= loc_ff[s-1];
            end
         end
         always_ff @(posedge clock) begin
            if (advance) begin
               tag_ff[s] <= tag_ff[s-1];
            end
         end
      end
   endgenerate

   logic [CW-1:0] e_w    [0:2];
   logic [CW-1:0] span_w [0:2];
   logic          out_w  [0:2];
   logic          on_w   [0:2];

   genvar d;
   generate
      for (d = 0; d < 3; d++) begin : g_dir
         if (d < DIRECTIONS) begin : g_lane
            tgpl_lane #(
               .MAX_KNOTS (MAX_KNOTS),
               .LANE_INDEX(d)
            ) u_lane (
               .clock   (clock),
               .reset   (reset),
               .advance (advance),
               .accept  (accept),
               .req     (req_payload),
               .n_in    (clamp_n(cfg_ff[d])),
               .elem    (e_w[d]),
               .span    (span_w[d]),
               .outside (out_w[d]),
               .online  (on_w[d])
            );
         end else begin : g_unused
            assign e_w[d]    = '0;
            assign span_w[d] = CW'(1);
            assign out_w[d]  = 1'b0;
            assign on_w[d]   = 1'b0;
         end
      end
   endgenerate

   // combine stage: inner part of the flat index
   logic          mid_valid_ff;
   logic [15:0]   mid_tag_ff;
   logic [CW-1:0] mid_e_ff [0:2];
   logic [CW-1:0] mid_span0_ff;
   logic [FW-1:0] mid_t_ff;
   logic          mid_out_ff;
   logic          mid_on_ff;
   logic [FW-1:0] mid_t_in;

   assign mid_t_in = FW'(e_w[1]) + FW'(span_w[1]) * FW'(e_w[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
      end else if (advance) begin
         mid_valid_ff <= loc_ff[LAST];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mid_tag_ff   <= tag_ff[LAST];
         mid_e_ff[0]  <= e_w[0];
         mid_e_ff[1]  <= e_w[1];
         mid_e_ff[2]  <= e_w[2];
         mid_span0_ff <= span_w[0];
         mid_t_ff     <= mid_t_in;
         mid_out_ff   <= out_w[0] || out_w[1] || out_w[2];
         mid_on_ff    <= on_w[0] || on_w[1] || on_w[2];
      end
   end

   // response register
   tgpl_pkg::rsp_type rsp_ff;
   tgpl_pkg::rsp_type rsp_in;

   always_comb begin
      rsp_in.tag_out          = mid_tag_ff;
      rsp_in.elem_x           = 8'(mid_e_ff[0]);
      rsp_in.elem_y           = 8'(mid_e_ff[1]);
      rsp_in.elem_z           = 8'(mid_e_ff[2]);
      rsp_in.elem_flat        = FW'(mid_e_ff[0]) + FW'(mid_span0_ff) * mid_t_ff;
      rsp_in.outside_range    = mid_out_ff;
      rsp_in.on_internal_line = mid_on_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= mid_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

>>> design/tgpl_checker.sv
// Port-level checker of the point locator, bound to the top level.
`include "tensor_grid_point_locator_assert.svh"

module tgpl_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_stall,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input tgpl_pkg::rsp_type                rsp_payload
);

   `TGPL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `TGPL_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_payload))
   `TGPL_ASSERT_IMPLY(a_stall_cause, clock, reset, req_stall || req_valid && req_stall, rsp_valid && rsp_stall)
   `TGPL_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid && !req_stall)

endmodule

bind tensor_grid_point_locator tgpl_checker u_checker (.*);
